>>> sv/rau_pkg.sv
package rau_pkg;

	localparam int WORD_BITS = 32;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int CNT_BITS = 7;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0] res_den;
		logic [1:0] status;
	} out_word_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0] status;
		logic [1:0] operation;
		logic neg_a;
		logic neg_b;
		logic [WORD_BITS-1:0] na;
		logic [WORD_BITS-1:0] da;
		logic [WORD_BITS-1:0] nb;
		logic [WORD_BITS-1:0] db;
	} job_t;

endpackage

>>> sv/rau_front.sv
module rau_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rau_pkg::in_word_t in_data,
	output logic job_valid,
	input  logic job_ready,
	output rau_pkg::job_t job_data
);

	localparam int W = rau_pkg::WORD_BITS;

	// two-entry queue
	rau_pkg::job_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	rau_pkg::job_t job_c;

	logic signed [W-1:0] an, ad, bn, bd;
	logic [W-1:0] man, mad, mbn, mbd;

	always_comb begin
		an = in_data.a_num[W-1:0];
		ad = in_data.a_den[W-1:0];
		bn = in_data.b_num[W-1:0];
		bd = in_data.b_den[W-1:0];
		man = an[W-1] ? (~an + 1'b1) : an;
		mad = ad[W-1] ? (~ad + 1'b1) : ad;
		mbn = bn[W-1] ? (~bn + 1'b1) : bn;
		mbd = bd[W-1] ? (~bd + 1'b1) : bd;
		job_c.operation = in_data.operation;
		job_c.na = man;
		job_c.da = mad;
		job_c.nb = mbn;
		job_c.db = mbd;
		job_c.neg_a = (an != '0) && (an[W-1] != ad[W-1]);
		job_c.neg_b = (bn != '0) && (bn[W-1] != bd[W-1]);
		// zero denominator checked first
		if (ad == '0 || bd == '0)
			job_c.status = rau_pkg::ST_ZERO_DEN;
		else if (in_data.operation == rau_pkg::OP_DIV && bn == '0)
			job_c.status = rau_pkg::ST_DIV_ZERO;
		else
			job_c.status = rau_pkg::ST_OK;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job_data = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (job_valid && job_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wr_q] <= job_c;
	end

endmodule

>>> sv/rau_back.sv
module rau_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  rau_pkg::job_t job_data,
	output logic out_valid,
	input  logic out_ready,
	output rau_pkg::out_word_t out_data
);

	localparam int W = rau_pkg::WORD_BITS;
	localparam int P = rau_pkg::PROD_BITS;
	localparam int C = rau_pkg::CNT_BITS;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL = 7'b0000010,
		S_SUM = 7'b0000100,
		S_GCD = 7'b0001000,
		S_DIVN = 7'b0010000,
		S_DIVD = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	rau_pkg::job_t job_q;
	logic [P-1:0] t1_q, t2_q, den_q, mag_q;
	logic neg_q;
	logic [P-1:0] gx_q, gy_q;
	logic [C-1:0] shift_q, cnt_q;
	logic [P-1:0] quo_q, rem_q, dvd_q;
	logic [P-1:0] qn_q;
	logic out_valid_q;
	rau_pkg::out_word_t out_q;
	rau_pkg::out_word_t res_q;

	// products: one 32x32 multiply each
	logic [P-1:0] p1, p2, p3;
	always_comb begin
		p1 = P'(job_q.na) * P'(job_q.db);
		p2 = P'(job_q.nb) * P'(job_q.da);
		p3 = P'(job_q.da) * P'(job_q.db);
		case (job_q.operation)
			rau_pkg::OP_MUL: begin
				p1 = P'(job_q.na) * P'(job_q.nb);
			end
			rau_pkg::OP_DIV: begin
				p3 = P'(job_q.da) * P'(job_q.nb);
			end
			default: ;
		endcase
	end

	// signed combine of the registered products
	logic nb_sign;
	logic [P-1:0] mag_c;
	logic neg_c;
	always_comb begin
		nb_sign = job_q.neg_b;
		if (job_q.operation == rau_pkg::OP_SUB)
			nb_sign = (job_q.nb != '0) && !job_q.neg_b;
		mag_c = t1_q;
		neg_c = job_q.neg_a != job_q.neg_b;
		if (job_q.operation == rau_pkg::OP_ADD || job_q.operation == rau_pkg::OP_SUB) begin
			if (job_q.neg_a == nb_sign) begin
				mag_c = t1_q + t2_q;
				neg_c = job_q.neg_a;
			end else if (t1_q >= t2_q) begin
				mag_c = t1_q - t2_q;
				neg_c = job_q.neg_a;
			end else begin
				mag_c = t2_q - t1_q;
				neg_c = nb_sign;
			end
		end
	end

	// binary gcd step
	logic [P-1:0] gdiff;
	assign gdiff = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;

	// restoring divide step
	logic [P:0] rtrial;
	logic [P-1:0] rshift;
	assign rshift = {rem_q[P-2:0], dvd_q[P-1]};
	assign rtrial = {1'b0, rshift} - {1'b0, gx_q};

	// final range check
	localparam logic [P-1:0] LIMIT = P'(1) << (W - 1);
	logic ovf;
	assign ovf = (neg_q ? (qn_q > LIMIT) : (qn_q > LIMIT - 1'b1)) || (quo_q > LIMIT - 1'b1);

	// finished word, loaded into the output register when it is free
	rau_pkg::out_word_t fin_c;
	always_comb begin
		fin_c = res_q;
		if (job_q.status == rau_pkg::ST_OK && mag_q != '0) begin
			if (ovf) begin
				fin_c.status = rau_pkg::ST_OVERFLOW;
				fin_c.res_num = '0;
				fin_c.res_den = '0;
			end else begin
				fin_c.status = rau_pkg::ST_OK;
				fin_c.res_num = 32'(signed'(neg_q ? -W'(qn_q) : W'(qn_q)));
				fin_c.res_den = 31'(quo_q);
			end
		end
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign job_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= (job_q.status != rau_pkg::ST_OK) ? S_DONE : S_SUM;
				end
				S_SUM: begin
					state_q <= (mag_c == '0) ? S_DONE : S_GCD;
				end
				S_GCD: begin
					if (gx_q == gy_q || gx_q == '0 || gy_q == '0) state_q <= S_DIVN;
					else if (gx_q[0] && gy_q[0]) state_q <= S_GCD;
				end
				S_DIVN: begin
					if (cnt_q == C'(P - 1)) state_q <= S_DIVD;
				end
				S_DIVD: begin
					if (cnt_q == C'(P - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				job_q <= job_data;
			end
			S_MUL: begin
				t1_q <= p1;
				t2_q <= p2;
				den_q <= p3;
				res_q.status <= job_q.status;
				res_q.res_num <= '0;
				res_q.res_den <= '0;
			end
			S_SUM: begin
				mag_q <= mag_c;
				neg_q <= neg_c;
				gx_q <= mag_c;
				gy_q <= den_q;
				shift_q <= '0;
				res_q.res_num <= '0;
				res_q.res_den <= 31'd1;
				res_q.status <= rau_pkg::ST_OK;
			end
			S_GCD: begin
				cnt_q <= '0;
				if (gx_q == gy_q || gx_q == '0 || gy_q == '0) begin
					gx_q <= ((gx_q == '0) ? gy_q : gx_q) << shift_q;
					dvd_q <= mag_q;
					rem_q <= '0;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					shift_q <= shift_q + 1'b1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else begin
					gx_q <= (gx_q < gy_q) ? gx_q : gy_q;
					gy_q <= gdiff;
				end
			end
			S_DIVN, S_DIVD: begin
				if (cnt_q == C'(P - 1)) begin
					cnt_q <= '0;
					rem_q <= '0;
					if (state_q == S_DIVN) begin
						qn_q <= {dvd_q[P-2:0], ~rtrial[P]};
						dvd_q <= den_q;
					end else begin
						quo_q <= {dvd_q[P-2:0], ~rtrial[P]};
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					dvd_q <= {dvd_q[P-2:0], ~rtrial[P]};
					rem_q <= rtrial[P] ? rshift : rtrial[P-1:0];
				end
			end
			S_DONE: begin
				if (out_load) out_q <= fin_c;
			end
			default: ;
		endcase
	end

endmodule

>>> sv/rational_arithmetic_unit_top.sv
// rational arithmetic unit: exact add, subtract, multiply, divide of two fractions
// input channel in_valid/in_ready carries one word: operation and two fractions
// output channel out_valid/out_ready carries one word: reduced num/den and status
// front: takes a word, normalizes signs and checks error cases combinationally,
// then queues it in a two-entry queue so it can keep accepting while back works
// back: registered 32x32 products, a registered signed sum, a binary gcd
// loop, then two 64-step restoring divides by the gcd
// one word at a time in the back part, so a new word enters back only after
// the last result is loaded into the output register
// error words go from the product step straight to done, zero results skip the
// gcd loop and the divides; gcd loop and serial divider set the rate
// reset clears the queue, the sequencer and the output valid flag
// a stalled receiver holds the result; back waits in its done step, the queue
// then fills and in_ready drops
module rational_arithmetic_unit_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rau_pkg::in_word_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rau_pkg::out_word_t out_data
);

	logic job_valid, job_ready;
	rau_pkg::job_t job_data;

	rau_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.job_valid(job_valid), .job_ready(job_ready), .job_data(job_data)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// error words carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != rau_pkg::ST_OK |->
		out_data.res_num == '0 && out_data.res_den == '0)
		else $error("error word with nonzero payload");

	// good words have positive denominator
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == rau_pkg::ST_OK |-> out_data.res_den != '0)
		else $error("zero denominator on good word");

	// a held result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

>>> dv/rational_arithmetic_unit_top_tb.sv
`timescale 1ns / 100ps

module rational_arithmetic_unit_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1200;
	localparam int LONG_HOLD = 3000;

	// exact fraction predictor and queue of expected results
	class fraction_scoreboard;
		rau_pkg::out_word_t pending[$];
		int n_errors;
		int n_checked;
		int n_status[4];

		function automatic logic [63:0] mag64(input logic signed [63:0] v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function automatic logic [63:0] gcd(input logic [63:0] x, input logic [63:0] y);
			logic [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function automatic rau_pkg::out_word_t compute(input rau_pkg::in_word_t w);
			rau_pkg::out_word_t r;
			logic signed [63:0] an, ad, bn, bd;
			logic [63:0] na, da, nb, db, t1, t2, mag, den, g, lim;
			logic sa, sb, neg;
			r = '0;
			an = 64'(w.a_num);
			ad = 64'(w.a_den);
			bn = 64'(w.b_num);
			bd = 64'(w.b_den);
			if (ad == 0 || bd == 0) begin
				r.status = rau_pkg::ST_ZERO_DEN;
				return r;
			end
			if (w.operation == rau_pkg::OP_DIV && bn == 0) begin
				r.status = rau_pkg::ST_DIV_ZERO;
				return r;
			end
			na = mag64(an);
			da = mag64(ad);
			nb = mag64(bn);
			db = mag64(bd);
			sa = (an != 0) && ((an < 0) != (ad < 0));
			sb = (bn != 0) && ((bn < 0) != (bd < 0));
			case (w.operation)
				rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
					t1 = na * db;
					t2 = nb * da;
					if (w.operation == rau_pkg::OP_SUB)
						sb = (nb != 0) && !sb;
					if (sa == sb) begin
						mag = t1 + t2;
						neg = sa;
					end else if (t1 >= t2) begin
						mag = t1 - t2;
						neg = sa;
					end else begin
						mag = t2 - t1;
						neg = sb;
					end
					den = da * db;
				end
				rau_pkg::OP_MUL: begin
					mag = na * nb;
					den = da * db;
					neg = sa != sb;
				end
				default: begin
					mag = na * db;
					den = da * nb;
					neg = sa != sb;
				end
			endcase
			if (mag == 0) begin
				r.res_den = 31'd1;
				return r;
			end
			g = gcd(mag, den);
			mag = mag / g;
			den = den / g;
			lim = 64'd1 << (rau_pkg::WORD_BITS - 1);
			if ((neg ? mag > lim : mag > lim - 1) || den > lim - 1) begin
				r.status = rau_pkg::ST_OVERFLOW;
				return r;
			end
			r.res_num = neg ? 32'(-mag) : 32'(mag);
			r.res_den = 31'(den);
			return r;
		endfunction

		function void note_input(input rau_pkg::in_word_t w);
			pending.push_back(compute(w));
		endfunction

		function void check_result(input rau_pkg::out_word_t got);
			rau_pkg::out_word_t exp_w;
			if (pending.size() == 0) begin
				$error("result with nothing expected: num %0d den %0d status %0d",
					got.res_num, got.res_den, got.status);
				n_errors++;
				return;
			end
			exp_w = pending.pop_front();
			n_checked++;
			n_status[exp_w.status]++;
			if (got.res_num !== exp_w.res_num) begin
				$error("res_num expected %0d actual %0d", exp_w.res_num, got.res_num);
				n_errors++;
			end
			if (got.res_den !== exp_w.res_den) begin
				$error("res_den expected %0d actual %0d", exp_w.res_den, got.res_den);
				n_errors++;
			end
			if (got.status !== exp_w.status) begin
				$error("status expected %0d actual %0d", exp_w.status, got.status);
				n_errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rau_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	rau_pkg::out_word_t out_data;

	fraction_scoreboard sb = new();
	bit hold_off;
	int idle_cycles;

	rational_arithmetic_unit_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one word and wait until it is taken
	task automatic send_word(input rau_pkg::in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
	endtask

	task automatic idle_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(0);
			3: return 32'(-$urandom_range(1, 16));
			4, 5: return 32'($urandom_range(1, 60));
			6: return 32'($urandom_range(1, 4000)) * 32'($urandom_range(1, 4000));
			default: return $urandom;
		endcase
	endfunction

	function automatic rau_pkg::in_word_t make_word(input logic [1:0] op,
			input logic [31:0] an, input logic [31:0] ad, input logic [31:0] bn,
			input logic [31:0] bd);
		rau_pkg::in_word_t w;
		w.operation = op;
		w.a_num = an;
		w.a_den = ad;
		w.b_num = bn;
		w.b_den = bd;
		return w;
	endfunction

	function automatic rau_pkg::in_word_t random_word();
		logic [31:0] ad, bd;
		ad = pick_value();
		bd = pick_value();
		// keep zero denominators rare so most words run the full path
		if ($urandom_range(0, 19) != 0 && ad == 0) ad = 32'd1;
		if ($urandom_range(0, 19) != 0 && bd == 0) bd = 32'd3;
		return make_word(2'($urandom), pick_value(), ad, pick_value(), bd);
	endfunction

	// receiver: random stall pattern, plus one long hold-off
	initial begin
		int phase;
		out_ready <= 1'b0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) out_ready <= 1'b0;
			else if (phase < 200) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
			phase = (phase + 1) % 600;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(out_data);
		end
	end

	// watchdog on cycles with no accepted word
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT && !hold_off) begin
				$display("watchdog expired with %0d results pending", sb.pending.size());
				$display("** rational_arithmetic_unit_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0] op;
		int burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		hold_off = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each operation, extremes, error cases
		for (int k = 0; k < 4; k++) begin
			op = 2'(k);
			send_word(make_word(op, 32'sd1, 32'sd2, 32'sd1, 32'sd3));
			send_word(make_word(op, -32'sd3, 32'sd4, 32'sd5, -32'sd6));
			send_word(make_word(op, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
				32'h8000_0000));
		end
		send_word(make_word(rau_pkg::OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1));
		send_word(make_word(rau_pkg::OP_DIV, 32'sd1, 32'sd1, 32'sd5, 32'sd0));
		send_word(make_word(rau_pkg::OP_DIV, 32'sd7, 32'sd3, 32'sd0, 32'sd9));
		send_word(make_word(rau_pkg::OP_SUB, 32'sd5, 32'sd7, 32'sd5, 32'sd7));
		send_word(make_word(rau_pkg::OP_MUL, 32'sd0, -32'sd7, 32'sd5, 32'sd7));
		send_word(make_word(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1));
		send_word(make_word(rau_pkg::OP_MUL, 32'h8000_0000, 32'sd1, -32'sd1, 32'sd1));
		send_word(make_word(rau_pkg::OP_MUL, 32'h8000_0000, 32'sd1, 32'sd1, 32'sd1));
		send_word(make_word(rau_pkg::OP_ADD, 32'sd1, 32'h7fff_ffff, 32'sd1, 32'h7fff_fffe));
		send_word(make_word(rau_pkg::OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h8000_0000));
		send_word(make_word(rau_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		send_word(make_word(rau_pkg::OP_SUB, 32'h8000_0000, 32'sd1, 32'h7fff_ffff, 32'sd1));
		wait_drained();

		// long receiver hold-off while words keep coming
		hold_off = 1'b1;
		fork
			begin
				repeat (LONG_HOLD) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 6; k++) send_word(random_word());
		join
		wait_drained();

		// random bursts with gaps
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
				send_word(random_word());
			if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 300));
		end
		wait_drained();
		repeat (400) @(posedge clk);

		$display("checked %0d results: ok %0d, zero den %0d, div by zero %0d, overflow %0d",
			sb.n_checked, sb.n_status[rau_pkg::ST_OK], sb.n_status[rau_pkg::ST_ZERO_DEN],
			sb.n_status[rau_pkg::ST_DIV_ZERO], sb.n_status[rau_pkg::ST_OVERFLOW]);
		if (sb.n_errors == 0 && sb.pending.size() == 0) begin
			$display("** rational_arithmetic_unit_top: PASSED **");
		end else begin
			$display("** rational_arithmetic_unit_top: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/rau_pkg.sv
sv/rau_front.sv
sv/rau_back.sv
sv/rational_arithmetic_unit_top.sv
dv/rational_arithmetic_unit_top_tb.sv
